@@ sv/two_stack_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// two_stack_queue_unit assertion macros
// Shared concurrent assertion forms for the two-stack queue RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_QUEUE_UNIT_DEFINES_SVH
`define TWO_STACK_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TSQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("two_stack_queue_unit: same-cycle check failed");

// next-cycle implication
`define TSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("two_stack_queue_unit: next-cycle check failed");

`endif

@@ sv/tsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tsq_pkg
// Word types, command and status codes for the two-stack queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

   localparam int DATA_W  = 32;
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 5;
   localparam int STAT_W  = 2;
   localparam int TOTAL_W = 6;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // commands
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] push_value;
      logic [IDX_W-1:0]         read_index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_data;
      logic [STAT_W-1:0]        status;
      logic [TOTAL_W-1:0]       item_count;
      logic                     is_full;
   } rsp_type;

endpackage

@@ sv/tsq_ram.sv @@
// ----------------------------------------------------------------------------
// tsq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

@@ sv/two_stack_queue_unit.sv @@
// ----------------------------------------------------------------------------
// two_stack_queue_unit: FIFO of signed words built from inbox/outbox stacks
// Push passes ST_DONE; pop/read pass ST_WAIT (registered RAM read), then ST_DONE.
// A move of the inbox adds ST_XFER first (one RAM read a cycle); req_stall holds while busy.
// The next word is accepted in the cycle after the result register loads; reset clears counts.
// ----------------------------------------------------------------------------
`include "two_stack_queue_unit_defines.svh"

module two_stack_queue_unit #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tsq_pkg::req_type              req_word,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tsq_pkg::rsp_type              rsp_word,
   // capacity register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tsq_pkg::CAP_W-1:0]     csr_wdata
);

   import tsq_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int EW = CW + 6;
   localparam logic [EW-1:0] DEPTH_E = EW'(STACK_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_XFER,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [CW-1:0]     in_cnt_ff, in_cnt_in;
   logic [CW-1:0]     out_cnt_ff, out_cnt_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     wr_idx_ff, wr_idx_in;
   logic              src_out_ff, src_out_in;
   req_type           req_ff, req_in;
   logic [DATA_W-1:0] res_data_ff, res_data_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // RAM ports
   logic              in_we, out_we;
   logic [AW-1:0]     in_waddr, in_raddr, out_waddr, out_raddr;
   logic [DATA_W-1:0] in_wdata, out_wdata, in_rdata, out_rdata;

   // widened views for compares
   logic [EW-1:0]     cap_e, eff_e, in_e, out_e, idx_e, n_e, rd_e;

   tsq_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH), .AW(AW)) u_inbox (
      .clock (clock),
      .we    (in_we),
      .waddr (in_waddr),
      .wdata (in_wdata),
      .raddr (in_raddr),
      .rdata (in_rdata)
   );

   tsq_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH), .AW(AW)) u_outbox (
      .clock (clock),
      .we    (out_we),
      .waddr (out_waddr),
      .wdata (out_wdata),
      .raddr (out_raddr),
      .rdata (out_rdata)
   );

   // effective capacity, clamped to 1 .. STACK_DEPTH
   always_comb begin
      cap_e = EW'(cap_ff);
      if (cap_e == '0) begin
         eff_e = EW'(1);
      end else if (cap_e > DEPTH_E) begin
         eff_e = DEPTH_E;
      end else begin
         eff_e = cap_e;
      end
      in_e  = EW'(in_cnt_ff);
      out_e = EW'(out_cnt_ff);
      idx_e = EW'(req_word.read_index);
      n_e   = EW'(n_ff);
      rd_e  = EW'(rd_cnt_ff);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // sequencer next-state and RAM control
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      in_cnt_in     = in_cnt_ff;
      out_cnt_in    = out_cnt_ff;
      n_in          = n_ff;
      rd_cnt_in     = rd_cnt_ff;
      pend_in       = pend_ff;
      wr_idx_in     = wr_idx_ff;
      src_out_in    = src_out_ff;
      req_in        = req_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      in_we         = 1'b0;
      in_waddr      = '0;
      in_wdata      = '0;
      in_raddr      = '0;
      out_we        = 1'b0;
      out_waddr     = '0;
      out_wdata     = '0;
      out_raddr     = '0;

      if (csr_valid) begin
         cap_in = csr_wdata;
      end

      // response word taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_word;
               res_data_in   = '0;
               res_status_in = STAT_OK;
               state_in      = ST_DONE;
               case (req_word.command)
                  CMD_PUSH: begin
                     if (in_e < eff_e) begin
                        in_we     = 1'b1;
                        in_waddr  = in_cnt_ff[AW-1:0];
                        in_wdata  = req_word.push_value;
                        in_cnt_in = in_cnt_ff + CW'(1);
                     end else if (out_cnt_ff == '0) begin
                        n_in      = in_cnt_ff;
                        rd_cnt_in = '0;
                        pend_in   = 1'b0;
                        wr_idx_in = '0;
                        state_in  = ST_XFER;
                     end else begin
                        res_status_in = STAT_REFUSED;
                     end
                  end
                  CMD_POP: begin
                     if (out_cnt_ff == '0 && in_cnt_ff != '0) begin
                        n_in      = in_cnt_ff;
                        rd_cnt_in = '0;
                        pend_in   = 1'b0;
                        wr_idx_in = '0;
                        state_in  = ST_XFER;
                     end else if (out_cnt_ff != '0) begin
                        out_raddr  = AW'(out_cnt_ff - CW'(1));
                        out_cnt_in = out_cnt_ff - CW'(1);
                        src_out_in = 1'b1;
                        state_in   = ST_WAIT;
                     end else begin
                        res_status_in = STAT_EMPTY;
                     end
                  end
                  CMD_READ: begin
                     if (idx_e < out_e) begin
                        out_raddr  = AW'(out_e - EW'(1) - idx_e);
                        src_out_in = 1'b1;
                        state_in   = ST_WAIT;
                     end else if (idx_e < out_e + in_e) begin
                        in_raddr   = AW'(idx_e - out_e);
                        src_out_in = 1'b0;
                        state_in   = ST_WAIT;
                     end else begin
                        res_status_in = STAT_RANGE;
                     end
                  end
                  default: begin
                     // unused code: report count only
                     res_status_in = STAT_OK;
                  end
               endcase
            end
         end

         ST_XFER: begin
            // read inbox top-down, write outbox bottom-up in the next cycle
            if (rd_e < n_e) begin
               in_raddr  = AW'(n_ff - CW'(1) - rd_cnt_ff);
               rd_cnt_in = rd_cnt_ff + CW'(1);
            end
            pend_in = (rd_e < n_e);
            if (pend_ff) begin
               out_we    = 1'b1;
               out_waddr = wr_idx_ff;
               out_wdata = in_rdata;
               wr_idx_in = wr_idx_ff + AW'(1);
            end
            // move finished: finish the pending push or pop
            if (rd_e == n_e && !pend_ff) begin
               out_cnt_in = n_ff;
               in_cnt_in  = '0;
               if (req_ff.command == CMD_PUSH) begin
                  in_we     = 1'b1;
                  in_waddr  = '0;
                  in_wdata  = req_ff.push_value;
                  in_cnt_in = CW'(1);
                  state_in  = ST_DONE;
               end else begin
                  out_raddr  = AW'(n_ff - CW'(1));
                  out_cnt_in = n_ff - CW'(1);
                  src_out_in = 1'b1;
                  state_in   = ST_WAIT;
               end
            end
         end

         ST_WAIT: begin
            res_data_in = src_out_ff ? out_rdata : in_rdata;
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.read_data  = res_data_ff;
               rsp_in.status     = res_status_ff;
               rsp_in.item_count = TOTAL_W'(in_e + out_e);
               rsp_in.is_full    = (in_e >= eff_e) && (out_e != '0);
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      rd_cnt_ff     <= rd_cnt_in;
      wr_idx_ff     <= wr_idx_in;
      src_out_ff    <= src_out_in;
      req_ff        <= req_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   // checks
   `TSQ_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, (in_e <= DEPTH_E) && (out_e <= DEPTH_E))
   `TSQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `TSQ_ASSERT_IMP(a_xfer_outbox_empty, clock, reset, state_ff == ST_XFER, out_cnt_ff == '0)

endmodule

@@ tb/two_stack_queue_unit_test.sv @@
// ----------------------------------------------------------------------------
// two_stack_queue_unit_test: self-checking bench for the two-stack queue
// Sends push, pop, indexed-read and unused commands under several capacity
// settings, predicts every result word with an in-bench queue model and
// compares each field. Random idle bursts fall on both channels.
// ----------------------------------------------------------------------------
module two_stack_queue_unit_test;
   import tsq_pkg::*;

   localparam int STACK_DEPTH  = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_WORDS  = 250;
   localparam int MAX_PRINTS   = 40;

   // command code with no operation behind it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_word;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_wdata = '0;

   // queue model state
   logic signed [DATA_W-1:0] inbox_mem  [STACK_DEPTH];
   logic signed [DATA_W-1:0] outbox_mem [STACK_DEPTH];
   int                       in_cnt  = 0;
   int                       out_cnt = 0;
   logic [CAP_W-1:0]         cap_reg = CAP_RESET;

   rsp_type pending_rsp [$];

   int gap_odds      = 0;
   int stall_odds    = 0;
   int stall_left    = 0;
   int mismatches    = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int caps_written  = 0;
   int cycle_count   = 0;

   two_stack_queue_unit #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // queue model
   // ------------------------------------------------------------------------

   // whole inbox onto the empty outbox, reversed
   function automatic void move_inbox_over();
      for (int j = 0; j < in_cnt; j++)
         outbox_mem[j] = inbox_mem[in_cnt - 1 - j];
      out_cnt = in_cnt;
      in_cnt  = 0;
   endfunction

   function automatic rsp_type queue_apply(input req_type w);
      rsp_type r;
      int      cap;
      int      idx;
      cap = int'(cap_reg);
      if (cap < 1) cap = 1;
      if (cap > STACK_DEPTH) cap = STACK_DEPTH;
      idx = int'(w.read_index);
      r = '0;
      r.status = STAT_OK;
      case (w.command)
         CMD_PUSH: begin
            if (in_cnt < cap) begin
               inbox_mem[in_cnt] = w.push_value;
               in_cnt++;
            end else if (out_cnt == 0) begin
               move_inbox_over();
               inbox_mem[0] = w.push_value;
               in_cnt = 1;
            end else begin
               r.status = STAT_REFUSED;
            end
         end
         CMD_POP: begin
            if (out_cnt == 0 && in_cnt > 0) move_inbox_over();
            if (out_cnt > 0) begin
               out_cnt--;
               r.read_data = outbox_mem[out_cnt];
            end else begin
               r.status = STAT_EMPTY;
            end
         end
         CMD_READ: begin
            // outbox top down, then inbox bottom up
            if (idx < out_cnt)
               r.read_data = outbox_mem[out_cnt - 1 - idx];
            else if (idx < out_cnt + in_cnt)
               r.read_data = inbox_mem[idx - out_cnt];
            else
               r.status = STAT_RANGE;
         end
         default: ;
      endcase
      r.item_count = TOTAL_W'(in_cnt + out_cnt);
      r.is_full    = (in_cnt >= cap) && (out_cnt > 0);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // result side: random stall bursts and checking
   // ------------------------------------------------------------------------

   // random stall bursts, odds set by stall_odds
   always @(posedge clock) begin
      if (reset || stall_odds == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(1, 100) <= stall_odds) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("mismatch at result %0d: %s expected %0h got %0h",
                  words_checked, what, want, got);
   endtask

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_word.read_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word.read_data !== want.read_data)
               report_mismatch("read_data", want.read_data, rsp_word.read_data);
            if (rsp_word.status !== want.status)
               report_mismatch("status", want.status, rsp_word.status);
            if (rsp_word.item_count !== want.item_count)
               report_mismatch("item_count", want.item_count, rsp_word.item_count);
            if (rsp_word.is_full !== want.is_full)
               report_mismatch("is_full", want.is_full, rsp_word.is_full);
         end
         words_checked++;
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   function automatic req_type make_req(input logic [CMD_W-1:0] cmd,
                                        input logic signed [DATA_W-1:0] val,
                                        input logic [IDX_W-1:0] idx);
      req_type w;
      w.command    = cmd;
      w.push_value = val;
      w.read_index = idx;
      return w;
   endfunction

   // send one word, predict its result, maybe idle afterwards
   task automatic send_req(input req_type w);
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(queue_apply(w));
      words_sent++;
      if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // hold off until every predicted result has come back
   task automatic drain_queue();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_queue();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_reg = value;
      caps_written++;
   endtask

   function automatic req_type random_req(input int push_pct);
      req_type w;
      int      roll;
      int      held;
      roll = $urandom_range(1, 100);
      if (roll <= push_pct)
         w.command = CMD_PUSH;
      else if (roll <= push_pct + (100 - push_pct) * 6 / 10)
         w.command = CMD_POP;
      else if ($urandom_range(0, 9) != 0)
         w.command = CMD_READ;
      else
         w.command = CMD_UNUSED;
      // mostly plain random words, sometimes an extreme
      case ($urandom_range(0, 19))
         0:       w.push_value = WORD_MIN;
         1:       w.push_value = WORD_MAX;
         2:       w.push_value = '0;
         3:       w.push_value = '1;
         default: w.push_value = $urandom;
      endcase
      // indexes mostly inside the queue or just past it
      held = in_cnt + out_cnt;
      if ($urandom_range(0, 3) != 0)
         w.read_index = IDX_W'($urandom_range(0, (held > 31) ? 31 : held));
      else
         w.read_index = IDX_W'($urandom_range(0, 31));
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // pop and read on an empty queue, unused command
   task automatic test_empty_queue();
      send_req(make_req(CMD_POP, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_READ, $urandom, 5'd0));
      send_req(make_req(CMD_UNUSED, $urandom, IDX_W'($urandom)));
   endtask

   // extreme words in and out, reads inside and past the count
   task automatic test_value_extremes();
      send_req(make_req(CMD_PUSH, WORD_MIN, 5'd0));
      send_req(make_req(CMD_PUSH, WORD_MAX, 5'd31));
      send_req(make_req(CMD_PUSH, '0, IDX_W'($urandom)));
      send_req(make_req(CMD_PUSH, '1, IDX_W'($urandom)));
      send_req(make_req(CMD_PUSH, 32'sh5555_5555, IDX_W'($urandom)));
      send_req(make_req(CMD_PUSH, 32'shAAAA_AAAA, IDX_W'($urandom)));
      send_req(make_req(CMD_READ, $urandom, 5'd5));
      send_req(make_req(CMD_READ, $urandom, 5'd6));
      send_req(make_req(CMD_READ, $urandom, 5'd31));
      send_req(make_req(CMD_POP, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_POP, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_READ, $urandom, 5'd0));
   endtask

   // capacity 0 acts as 1: move on full inbox, refusal, then 31 acts as 16
   task automatic test_capacity_clamp();
      while (in_cnt + out_cnt != 0)
         send_req(make_req(CMD_POP, $urandom, IDX_W'($urandom)));
      write_capacity(5'd0);
      send_req(make_req(CMD_PUSH, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_PUSH, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_PUSH, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_READ, $urandom, 5'd1));
      send_req(make_req(CMD_POP, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_POP, $urandom, IDX_W'($urandom)));
      write_capacity(5'd31);
   endtask

   // capacity lowered under the inbox count: the whole inbox still moves
   task automatic test_capacity_lowered();
      repeat (3) send_req(make_req(CMD_PUSH, $urandom, IDX_W'($urandom)));
      write_capacity(5'd2);
      send_req(make_req(CMD_PUSH, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_PUSH, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_PUSH, $urandom, IDX_W'($urandom)));
      send_req(make_req(CMD_READ, $urandom, 5'd3));
   endtask

   // random phases over a spread of capacities and idle rates
   task automatic test_random_traffic();
      logic [CAP_W-1:0] caps [7];
      int               push_pct;
      caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8, 5'd16};
      caps[5] = CAP_W'($urandom_range(2, 15));
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 10;
            default: gap_odds = 35;
         endcase
         case ($urandom_range(0, 2))
            0:       stall_odds = 0;
            1:       stall_odds = 10;
            default: stall_odds = 35;
         endcase
         push_pct = $urandom_range(25, 75);
         repeat (PHASE_WORDS) send_req(random_req(push_pct));
      end
   endtask

   // closing stretch with no idling on either side
   task automatic test_steady_stream();
      drain_queue();
      gap_odds   = 0;
      stall_odds = 0;
      write_capacity(CAP_W'($urandom_range(1, 16)));
      repeat (PHASE_WORDS) send_req(random_req(50));
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_value_extremes();
      gap_odds   = 20;
      stall_odds = 20;
      test_capacity_clamp();
      test_capacity_lowered();
      test_random_traffic();
      test_steady_stream();

      drain_queue();
      repeat (40) @(posedge clock);

      $display("covered %0d request words and %0d result words over %0d capacity writes",
               words_sent, words_checked, caps_written);
      $display("push, pop, indexed read, unused command, clamped and lowered capacity");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
